### rtl/mat4_vector_transform_unit_assert.svh
// Assertion macros shared by the matrix-vector transform RTL.
// Included by the top level, the only file that carries concurrent checks; no other dependencies.
`ifndef MAT4_VECTOR_TRANSFORM_UNIT_ASSERT_SVH
`define MAT4_VECTOR_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MVT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MVT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mvt_pkg.sv
// Package for the 4x4 matrix-vector transform: widths, types, register reset values.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

    localparam int DATA_W      = 32;              // Q16.16 element
    localparam int PROD_W      = 2 * DATA_W;      // Q32.32 product
    localparam int PAIR_W      = PROD_W + 1;      // sum of two products
    localparam int SUM_W       = PROD_W + 2;      // sum of four products
    localparam int FRAC_W      = 16;
    localparam int NUM_LANES   = 4;
    localparam int NUM_REGS    = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int REG_SEL_W   = $clog2(NUM_REGS);

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef q16_t [NUM_LANES-1:0]      vec4_t;
    typedef logic [CFG_DATA_W-1:0]     cfg_word_t;
    typedef cfg_word_t [NUM_REGS-1:0]  cfg_bank_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_COL0_ROWS01 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COL0_ROWS23 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COL1_ROWS01 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COL1_ROWS23 = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COL2_ROWS01 = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COL2_ROWS23 = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_COL3_ROWS01 = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_COL3_ROWS23 = 8'd7;

    // Identity matrix after reset.
    localparam cfg_word_t ONE_LOW  = 64'h0000_0000_0001_0000;
    localparam cfg_word_t ONE_HIGH = 64'h0001_0000_0000_0000;
    localparam cfg_bank_t CFG_RESET = '{
        REG_COL3_ROWS23: ONE_HIGH,
        REG_COL3_ROWS01: '0,
        REG_COL2_ROWS23: ONE_LOW,
        REG_COL2_ROWS01: '0,
        REG_COL1_ROWS23: '0,
        REG_COL1_ROWS01: ONE_HIGH,
        REG_COL0_ROWS23: '0,
        REG_COL0_ROWS01: ONE_LOW
    };

    localparam q16_t SAT_MAX = 32'sh7FFF_FFFF;
    localparam q16_t SAT_MIN = 32'sh8000_0000;

    // Load enables of the three lane stages.
    typedef struct packed {
        logic mul_en;
        logic pair_en;
        logic sum_en;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

### rtl/mat4_vector_transform_unit.sv
// Top level of the 4x4 matrix times 4-vector transform, signed Q16.16.
// Depends on mvt_pkg, mvt_row_lane, mvt_merge and mat4_vector_transform_unit_assert.svh.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_tvalid/s_tready    s_tdata: vec_x, vec_y, vec_z, vec_w
//   m_       out        m_tvalid/m_tready    m_tdata: out_x, out_y, out_z, out_w
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data (64-bit register)
//
// One vector per cycle sustained while m_tready stays high; an accepted vector passes
// four registers: multiply, pair add, final add + shift + saturate, output register.
// Four row lanes run side by side, each with four 32x32 multipliers.
// aresetn is synchronous, active low: empties the pipeline and loads the identity matrix.
// A stalled output holds its transaction; the stages behind it keep filling bubbles
// and s_tready drops only once every stage holds an item.
// cfg_ready is always high; writes to an index beyond 7 are dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "mat4_vector_transform_unit_assert.svh"

module mat4_vector_transform_unit
    import mvt_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // vec_x [31:0], vec_y [63:32], vec_z [95:64], vec_w [127:96]
    input  wire logic [NUM_LANES*DATA_W-1:0] s_tdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
    output logic [NUM_LANES*DATA_W-1:0]      m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

    // Matrix registers, two rows of one column per word.
    cfg_bank_t  cfg_reg;
    cfg_bank_t  cfg_next;
    logic       cfg_hit;

    // Stage occupancy of the lane pipeline.
    logic       mul_v_reg,  mul_v_next;
    logic       pair_v_reg, pair_v_next;
    logic       sum_v_reg,  sum_v_next;
    pipe_ctrl_t ctrl;
    logic       load_ok;

    vec4_t      vec;
    vec4_t      lane_result;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index < CFG_INDEX_W'(NUM_REGS));

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_hit) begin
            cfg_next[cfg_index[REG_SEL_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Advance a stage when it is empty or the stage after it advances.
    always_comb begin
        ctrl.sum_en  = !sum_v_reg  || load_ok;
        ctrl.pair_en = !pair_v_reg || ctrl.sum_en;
        ctrl.mul_en  = !mul_v_reg  || ctrl.pair_en;
        mul_v_next   = ctrl.mul_en  ? s_tvalid   : mul_v_reg;
        pair_v_next  = ctrl.pair_en ? mul_v_reg  : pair_v_reg;
        sum_v_next   = ctrl.sum_en  ? pair_v_reg : sum_v_reg;
    end

    assign s_tready = ctrl.mul_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg  <= 1'b0;
            pair_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
        end else begin
            mul_v_reg  <= mul_v_next;
            pair_v_reg <= pair_v_next;
            sum_v_reg  <= sum_v_next;
        end
    end

    assign vec = s_tdata;

    // One lane per output row; column c of row r sits in word 2c + r/2, half r%2.
    for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
        vec4_t row_elem;
        for (genvar c = 0; c < NUM_LANES; c++) begin : g_col
            localparam int WORD = 2 * c + r / 2;
            localparam int HALF = (r % 2) * DATA_W;
            assign row_elem[c] = cfg_reg[WORD][HALF +: DATA_W];
        end
        mvt_row_lane u_lane (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .row_elem (row_elem),
            .vec      (vec),
            .result   (lane_result[r])
        );
    end

    mvt_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (sum_v_reg),
        .lane_result (lane_result),
        .load_ok     (load_ok),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Checks on pipeline flow and configuration.
    `MVT_ASSERT_NEXT(a_accept_fills_mul, aclk, aresetn, s_tvalid && s_tready, mul_v_reg, "accepted transaction did not enter the multiply stage")
    `MVT_ASSERT_SAME(a_full_blocks_input, aclk, aresetn, m_tvalid && !m_tready && mul_v_reg && pair_v_reg && sum_v_reg, !s_tready, "input accepted with a full stalled pipeline")
    `MVT_ASSERT_NEXT(a_sum_held_on_stall, aclk, aresetn, sum_v_reg && !load_ok, sum_v_reg, "result dropped while output stalled")
    `MVT_ASSERT_NEXT(a_bad_index_ignored, aclk, aresetn, !cfg_hit, $stable(cfg_reg), "matrix changed without a valid register write")

endmodule

`default_nettype wire

### rtl/mvt_row_lane.sv
// One row lane: four Q16.16 products, pairwise add, final add with floor shift and saturation.
// Depends on mvt_pkg; instanced once per output row by the top level.
`timescale 1ns / 1ps
`default_nettype none

module mvt_row_lane
    import mvt_pkg::*;
(
    input  wire logic       aclk,
    input  wire pipe_ctrl_t ctrl,
    input  wire vec4_t      row_elem,   // matrix row, columns 0..3
    input  wire vec4_t      vec,        // x, y, z, w
    output q16_t            result
);

    logic signed [PROD_W-1:0] prod_reg [NUM_LANES];
    logic signed [PROD_W-1:0] prod_next [NUM_LANES];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum_full;
    q16_t                     result_reg;
    q16_t                     result_next;
    logic                     in_range;

    always_comb begin
        for (int c = 0; c < NUM_LANES; c++) begin
            prod_next[c] = $signed(row_elem[c]) * $signed(vec[c]);
        end
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
    end

    // Floor shift keeps bits above the fraction; saturate when the top bits disagree.
    always_comb begin
        sum_full = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        in_range = (&sum_full[SUM_W-1:FRAC_W+DATA_W-1])
                || !(|sum_full[SUM_W-1:FRAC_W+DATA_W-1]);
        if (in_range) begin
            result_next = sum_full[FRAC_W+DATA_W-1:FRAC_W];
        end else if (sum_full[SUM_W-1]) begin
            result_next = SAT_MIN;
        end else begin
            result_next = SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            for (int c = 0; c < NUM_LANES; c++) begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (ctrl.pair_en) begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
        if (ctrl.sum_en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/mvt_merge.sv
// Merge stage: gathers the four lane results into one output transaction register.
// Depends on mvt_pkg; drives the master-side stream of the top level.
`timescale 1ns / 1ps
`default_nettype none

module mvt_merge
    import mvt_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    input  wire vec4_t                      lane_result,
    output logic                            load_ok,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [NUM_LANES*DATA_W-1:0]     m_tdata
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [NUM_LANES*DATA_W-1:0] data_reg;

    // Take a new result when empty or when the current one leaves this cycle.
    assign load_ok    = !valid_reg || m_tready;
    assign valid_next = load_ok ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok && in_valid) begin
            data_reg <= lane_result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire
